>>> rtl/core/spq_pkg.sv
// Shared types and codes for the sorted priority queue.
package spq_pkg;

  localparam int unsigned PayloadFieldW  = 32;
  localparam int unsigned PriorityFieldW = 8;
  localparam int unsigned OccFieldW      = 5;

  typedef enum logic {
    SPQ_INSERT = 1'b0,
    SPQ_REMOVE = 1'b1
  } spq_action_e;

  typedef enum logic [1:0] {
    SPQ_OK    = 2'd0,
    SPQ_EMPTY = 2'd1,
    SPQ_FULL  = 2'd2
  } spq_status_e;

  typedef struct packed {
    spq_action_e               action;
    logic [PayloadFieldW-1:0]  item_payload;
    logic [PriorityFieldW-1:0] item_priority;
  } spq_in_t;

  typedef struct packed {
    logic [PayloadFieldW-1:0]  out_payload;
    logic [PriorityFieldW-1:0] out_priority;
    spq_status_e               status;
    logic [OccFieldW-1:0]      occupancy;
  } spq_out_t;

  typedef struct packed {
    logic ins;
    logic rem;
  } spq_cell_ctrl_t;

endpackage

>>> rtl/core/spq_cell.sv
// One slot of the sorted chain: holds an entry, shifts down on insert, up on remove.
module spq_cell
  import spq_pkg::*;
#(
  parameter int unsigned PayW = 32,
  parameter int unsigned PriW = 8
) (
  input  logic           clk_i,
  input  spq_cell_ctrl_t ctrl_i,
  input  logic           occ_i,
  input  logic [PayW-1:0] new_pay_i,
  input  logic [PriW-1:0] new_pri_i,
  input  logic           prev_stay_i,
  input  logic [PayW-1:0] prev_pay_i,
  input  logic [PriW-1:0] prev_pri_i,
  input  logic [PayW-1:0] next_pay_i,
  input  logic [PriW-1:0] next_pri_i,
  output logic           stay_o,
  output logic [PayW-1:0] pay_o,
  output logic [PriW-1:0] pri_o
);

  logic [PayW-1:0] pay_q, pay_d;
  logic [PriW-1:0] pri_q, pri_d;

  assign stay_o = occ_i && (pri_q >= new_pri_i);

  always_comb begin
    pay_d = pay_q;
    pri_d = pri_q;
    priority if (ctrl_i.ins) begin
      if (!stay_o) begin
        if (prev_stay_i) begin
          pay_d = new_pay_i;
          pri_d = new_pri_i;
        end else begin
          pay_d = prev_pay_i;
          pri_d = prev_pri_i;
        end
      end
    end else if (ctrl_i.rem) begin
      pay_d = next_pay_i;
      pri_d = next_pri_i;
    end
  end

  always_ff @(posedge clk_i) begin
    pay_q <= pay_d;
    pri_q <= pri_d;
  end

  assign pay_o = pay_q;
  assign pri_o = pri_q;

endmodule

>>> rtl/core/stable_priority_queue_core.sv
// Top level of the sorted priority queue: chain of slots, entry count and result register.
// Result: each accepted transaction's result is captured in the output register.
// Throughput: one transaction per cycle unless a held result stalls the input; every slot
// compares with the new priority at once and shifts by one position in the same update.
// Reset: asynchronous, active low; clears the entry count and the result valid flag.
// Slot contents are not reset and are only read below the entry count.
module stable_priority_queue_core
  import spq_pkg::*;
#(
  parameter int unsigned DEPTH         = 16,
  parameter int unsigned PAYLOAD_BITS  = 32,
  parameter int unsigned PRIORITY_BITS = 8
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  spq_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output spq_out_t out_data_o
);

  localparam int unsigned PayW =
      (PAYLOAD_BITS < PayloadFieldW) ? PAYLOAD_BITS : PayloadFieldW;
  localparam int unsigned PriW =
      (PRIORITY_BITS < PriorityFieldW) ? PRIORITY_BITS : PriorityFieldW;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [CntW-1:0] count_q, count_d;
  logic            out_valid_q;
  spq_out_t        out_data_q, out_data_d;

  logic            accept;
  logic            is_remove;
  logic            empty;
  logic            full;
  spq_cell_ctrl_t  ctrl;
  logic [PayW-1:0] new_pay;
  logic [PriW-1:0] new_pri;

  logic [PayW-1:0] pay   [DEPTH];
  logic [PriW-1:0] pri   [DEPTH];
  logic            stay  [DEPTH];

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_remove  = (in_data_i.action == SPQ_REMOVE);
  assign empty      = (count_q == '0);
  assign full       = (count_q == CntW'(DEPTH));
  assign new_pay    = in_data_i.item_payload[PayW-1:0];
  assign new_pri    = in_data_i.item_priority[PriW-1:0];

  assign ctrl.ins = accept && !is_remove && !full;
  assign ctrl.rem = accept && is_remove && !empty;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic            occ;
    logic            prev_stay;
    logic [PayW-1:0] prev_pay, next_pay;
    logic [PriW-1:0] prev_pri, next_pri;

    assign occ = (CntW'(i) < count_q);

    if (i == 0) begin : g_head
      assign prev_stay = 1'b1;
      assign prev_pay  = new_pay;
      assign prev_pri  = new_pri;
    end else begin : g_body
      assign prev_stay = stay[i-1];
      assign prev_pay  = pay[i-1];
      assign prev_pri  = pri[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign next_pay = pay[i];
      assign next_pri = pri[i];
    end else begin : g_mid
      assign next_pay = pay[i+1];
      assign next_pri = pri[i+1];
    end

    spq_cell #(
      .PayW(PayW),
      .PriW(PriW)
    ) u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .occ_i      (occ),
      .new_pay_i  (new_pay),
      .new_pri_i  (new_pri),
      .prev_stay_i(prev_stay),
      .prev_pay_i (prev_pay),
      .prev_pri_i (prev_pri),
      .next_pay_i (next_pay),
      .next_pri_i (next_pri),
      .stay_o     (stay[i]),
      .pay_o      (pay[i]),
      .pri_o      (pri[i])
    );
  end

  always_comb begin
    count_d                 = count_q;
    out_data_d              = out_data_q;
    out_data_d.out_payload  = '0;
    out_data_d.out_priority = '0;
    out_data_d.status       = SPQ_OK;
    unique case (in_data_i.action)
      SPQ_REMOVE: begin
        if (empty) begin
          out_data_d.status = SPQ_EMPTY;
        end else begin
          out_data_d.out_payload  = PayloadFieldW'(pay[0]);
          out_data_d.out_priority = PriorityFieldW'(pri[0]);
          count_d                 = count_q - CntW'(1);
        end
      end
      SPQ_INSERT: begin
        if (full) begin
          out_data_d.status = SPQ_FULL;
        end else begin
          count_d = count_q + CntW'(1);
        end
      end
      default: out_data_d.status = SPQ_OK;
    endcase
    out_data_d.occupancy = OccFieldW'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

>>> rtl/core/spq_checker.sv
// Port-level assertions for the sorted priority queue, bound to the top level.
module spq_checker
  import spq_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_ready_o,
  input spq_in_t  in_data_i,
  input logic     out_valid_o,
  input logic     out_ready_i,
  input spq_out_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  a_ready_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without a pending result");

  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == SPQ_EMPTY |->
      out_data_o.out_payload == '0 && out_data_o.out_priority == '0 &&
      out_data_o.occupancy == '0)
    else $error("remove on empty returned data");

  a_full_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == SPQ_FULL |->
      out_data_o.occupancy == OccFieldW'(DEPTH) && out_data_o.out_payload == '0)
    else $error("dropped insert with wrong occupancy");

endmodule

bind stable_priority_queue_core spq_checker #(.DEPTH(DEPTH)) u_spq_checker (.*);

>>> dv/tb.sv
// Self-checking testbench for the sorted stable priority queue core.
module tb;
  import spq_pkg::*;

  localparam int unsigned QDepth = 16;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_ready_o;
  spq_in_t  in_data_i   = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b1;
  spq_out_t out_data_o;

  logic [PayloadFieldW-1:0]  slot_payload  [QDepth];
  logic [PriorityFieldW-1:0] slot_priority [QDepth];
  int unsigned               slot_count = 0;

  spq_out_t    pending_results [$];
  int unsigned fail_count = 0;
  bit          quiet_tail = 1'b0;

  stable_priority_queue_core #(
    .DEPTH        (QDepth),
    .PAYLOAD_BITS (PayloadFieldW),
    .PRIORITY_BITS(PriorityFieldW)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  initial begin
    #1_000_000;
    $display("stable_priority_queue_core regression: fail");
    $finish;
  end

  function automatic spq_out_t queue_step(spq_in_t item);
    spq_out_t    res;
    int unsigned pos;
    res = '0;
    if (item.action == SPQ_REMOVE) begin
      if (slot_count == 0) begin
        res.status = SPQ_EMPTY;
      end else begin
        res.out_payload  = slot_payload[0];
        res.out_priority = slot_priority[0];
        for (int unsigned k = 1; k < slot_count; k++) begin
          slot_payload[k-1]  = slot_payload[k];
          slot_priority[k-1] = slot_priority[k];
        end
        slot_count--;
        res.status = SPQ_OK;
      end
    end else if (slot_count >= QDepth) begin
      res.status = SPQ_FULL;
    end else begin
      pos = 0;
      while (pos < slot_count && slot_priority[pos] >= item.item_priority) pos++;
      for (int unsigned k = slot_count; k > pos; k--) begin
        slot_payload[k]  = slot_payload[k-1];
        slot_priority[k] = slot_priority[k-1];
      end
      slot_payload[pos]  = item.item_payload;
      slot_priority[pos] = item.item_priority;
      slot_count++;
      res.status = SPQ_OK;
    end
    res.occupancy = slot_count[OccFieldW-1:0];
    return res;
  endfunction

  function automatic spq_in_t random_item(int unsigned insert_pct, bit tie_heavy);
    spq_in_t     item;
    int unsigned pick;
    item.action = ($urandom_range(0, 99) < insert_pct) ? SPQ_INSERT : SPQ_REMOVE;
    pick = $urandom_range(0, 15);
    if (pick == 0)      item.item_payload = '0;
    else if (pick == 1) item.item_payload = '1;
    else                item.item_payload = $urandom;
    pick = $urandom_range(0, 15);
    if (pick == 0)      item.item_priority = '0;
    else if (pick == 1) item.item_priority = '1;
    else if (tie_heavy) item.item_priority = PriorityFieldW'($urandom_range(126, 129));
    else                item.item_priority = PriorityFieldW'($urandom_range(0, 255));
    return item;
  endfunction

  task automatic send_item(spq_in_t item, bit may_idle);
    if (may_idle && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_results.push_back(queue_step(item));
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  task automatic test_remove_empty();
    spq_in_t item;
    item = '{action: SPQ_REMOVE, item_payload: '0, item_priority: '0};
    send_item(item, 1'b0);
    item = '{action: SPQ_REMOVE, item_payload: '1, item_priority: '1};
    send_item(item, 1'b1);
  endtask

  task automatic test_fill_overflow();
    spq_in_t item;
    for (int k = 0; k < QDepth; k++) begin
      item.action = SPQ_INSERT;
      case (k % 4)
        0:       item.item_priority = '1;
        1:       item.item_priority = '0;
        default: item.item_priority = 8'h80;
      endcase
      if (k == 0)      item.item_payload = '0;
      else if (k == 1) item.item_payload = '1;
      else             item.item_payload = 32'hA5A5_0000 | k;
      send_item(item, 1'b1);
    end
    item = '{action: SPQ_INSERT, item_payload: '1, item_priority: '1};
    send_item(item, 1'b0);
    item = '{action: SPQ_INSERT, item_payload: '0, item_priority: '0};
    send_item(item, 1'b1);
    repeat (4) begin
      item = '{action: SPQ_REMOVE, item_payload: '1, item_priority: '1};
      send_item(item, 1'b1);
    end
  endtask

  task automatic test_random_traffic(int unsigned n_items, bit may_idle);
    int unsigned sent;
    int unsigned block_len;
    int unsigned insert_pct;
    bit          block_idle;
    bit          ties;
    sent = 0;
    while (sent < n_items) begin
      case ($urandom_range(0, 3))
        0:       insert_pct = 25;
        1:       insert_pct = 50;
        2:       insert_pct = 75;
        default: insert_pct = 90;
      endcase
      block_len  = $urandom_range(20, 60);
      block_idle = may_idle && ($urandom_range(0, 3) != 0);
      ties       = 1'($urandom_range(0, 1));
      for (int unsigned k = 0; k < block_len && sent < n_items; k++) begin
        send_item(random_item(insert_pct, ties), block_idle);
        sent++;
      end
    end
  endtask

  task automatic test_drain_pause();
    test_random_traffic(30, 1'b1);
    wait_drained();
    test_random_traffic(30, 1'b1);
  endtask

  initial begin
    forever begin
      @(posedge clk_i);
      if (!quiet_tail && $urandom_range(0, 9) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else if ($urandom_range(0, 31) == 0) begin
        repeat ($urandom_range(20, 80)) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    spq_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data_o);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_data_o.out_payload !== want.out_payload) begin
          $display("%0t: out_payload expected %h actual %h", $time,
                   want.out_payload, out_data_o.out_payload);
          fail_count++;
        end
        if (out_data_o.out_priority !== want.out_priority) begin
          $display("%0t: out_priority expected %h actual %h", $time,
                   want.out_priority, out_data_o.out_priority);
          fail_count++;
        end
        if (out_data_o.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time,
                   want.status, out_data_o.status);
          fail_count++;
        end
        if (out_data_o.occupancy !== want.occupancy) begin
          $display("%0t: occupancy expected %0d actual %0d", $time,
                   want.occupancy, out_data_o.occupancy);
          fail_count++;
        end
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_remove_empty();
    test_fill_overflow();
    test_random_traffic(900, 1'b1);
    test_drain_pause();
    quiet_tail <= 1'b1;
    test_random_traffic(390, 1'b0);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("stable_priority_queue_core regression: pass");
    end else begin
      $display("stable_priority_queue_core regression: fail");
    end
    $finish;
  end

endmodule
